/* hw/rtl/ple_pkg.sv */
`timescale 1ns / 1ps

package ple_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 11;
  localparam int LEN_W  = 11;

  localparam logic [DATA_W-1:0] NEG_ONE = {DATA_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_MOVE   = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_QCAP,
    S_MVCAP,
    S_SH_PRIME,
    S_SH_RUN,
    S_WR_VAL,
    S_WR_MOVED,
    S_REM_FIN,
    S_SC_PRIME,
    S_SC_RUN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic set_result;
    logic rd_pos;
    logic cap_query;
    logic cap_moved;
    logic sh_prime;
    logic sh_run;
    logic wr_val;
    logic wr_moved;
    logic rem_fin;
    logic max_clear;
    logic sc_prime;
    logic sc_run;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic err;
    logic no_shift;
    logic shift_last;
    logic scan_last;
    logic count_one;
  } stat_t;

endpackage

/* hw/rtl/ple_ram.sv */
`timescale 1ns / 1ps

module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/ple_ctrl.sv */
`timescale 1ns / 1ps

module ple_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  ple_pkg::stat_t st,
  output ple_pkg::ctl_t  ctl,
  output logic          busy,
  output logic          done
);

  ple_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ple_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ple_pkg::S_IDLE: begin
        if (start) state_next = ple_pkg::S_DECODE;
      end
      ple_pkg::S_DECODE: begin
        if (st.err) begin
          state_next = ple_pkg::S_DONE;
        end else begin
          unique case (st.cmd)
            ple_pkg::CMD_INSERT: state_next = st.no_shift ? ple_pkg::S_WR_VAL
                                                          : ple_pkg::S_SH_PRIME;
            ple_pkg::CMD_REMOVE: state_next = st.no_shift ? ple_pkg::S_REM_FIN
                                                          : ple_pkg::S_SH_PRIME;
            ple_pkg::CMD_MOVE:   state_next = ple_pkg::S_MVCAP;
            ple_pkg::CMD_QUERY:  state_next = ple_pkg::S_QCAP;
            default:             state_next = ple_pkg::S_DONE;
          endcase
        end
      end
      ple_pkg::S_QCAP:     state_next = ple_pkg::S_DONE;
      ple_pkg::S_MVCAP:    state_next = st.no_shift ? ple_pkg::S_DONE : ple_pkg::S_SH_PRIME;
      ple_pkg::S_SH_PRIME: state_next = ple_pkg::S_SH_RUN;
      ple_pkg::S_SH_RUN: begin
        if (st.shift_last) begin
          unique case (st.cmd)
            ple_pkg::CMD_INSERT: state_next = ple_pkg::S_WR_VAL;
            ple_pkg::CMD_REMOVE: state_next = ple_pkg::S_REM_FIN;
            ple_pkg::CMD_MOVE:   state_next = ple_pkg::S_WR_MOVED;
            default:             state_next = ple_pkg::S_DONE;
          endcase
        end
      end
      ple_pkg::S_WR_VAL:   state_next = ple_pkg::S_DONE;
      ple_pkg::S_WR_MOVED: state_next = ple_pkg::S_DONE;
      ple_pkg::S_REM_FIN:  state_next = st.count_one ? ple_pkg::S_DONE : ple_pkg::S_SC_PRIME;
      ple_pkg::S_SC_PRIME: state_next = ple_pkg::S_SC_RUN;
      ple_pkg::S_SC_RUN: begin
        if (st.scan_last) state_next = ple_pkg::S_DONE;
      end
      ple_pkg::S_DONE:     state_next = ple_pkg::S_IDLE;
      default:             state_next = ple_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      ple_pkg::S_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
      end
      ple_pkg::S_DECODE: begin
        ctl.set_result = 1'b1;
        ctl.rd_pos     = 1'b1;
      end
      ple_pkg::S_QCAP:     ctl.cap_query = 1'b1;
      ple_pkg::S_MVCAP:    ctl.cap_moved = 1'b1;
      ple_pkg::S_SH_PRIME: ctl.sh_prime  = 1'b1;
      ple_pkg::S_SH_RUN:   ctl.sh_run    = 1'b1;
      ple_pkg::S_WR_VAL:   ctl.wr_val    = 1'b1;
      ple_pkg::S_WR_MOVED: ctl.wr_moved  = 1'b1;
      ple_pkg::S_REM_FIN: begin
        ctl.rem_fin   = 1'b1;
        ctl.max_clear = st.count_one;
      end
      ple_pkg::S_SC_PRIME: ctl.sc_prime  = 1'b1;
      ple_pkg::S_SC_RUN:   ctl.sc_run    = 1'b1;
      ple_pkg::S_DONE:     done          = 1'b1;
      default:             busy          = 1'b1;
    endcase
  end

endmodule

/* hw/rtl/ple_datapath.sv */
`timescale 1ns / 1ps

module ple_datapath #(
  parameter int CAPACITY = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ple_pkg::ctl_t                       ctl,
  input  logic [1:0]                          cmd,
  input  logic [ple_pkg::POS_W-1:0]           pos,
  input  logic signed [ple_pkg::DATA_W-1:0]   value,
  output ple_pkg::stat_t                      st,
  output logic signed [ple_pkg::DATA_W-1:0]   data,
  output logic [ple_pkg::LEN_W-1:0]           length,
  output logic signed [ple_pkg::DATA_W-1:0]   maximum,
  output logic [1:0]                          status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

  ple_pkg::cmd_t                     cmd_q;
  logic [ple_pkg::POS_W-1:0]         pos_q;
  logic signed [ple_pkg::DATA_W-1:0] val_q;
  logic signed [ple_pkg::DATA_W-1:0] moved;
  logic signed [ple_pkg::DATA_W-1:0] data_r;
  ple_pkg::status_t                  status_r;
  logic [CW-1:0]                     count;
  logic signed [ple_pkg::DATA_W-1:0] max_r;
  logic [AW-1:0]                     rd_ptr;
  logic [AW-1:0]                     wr_ptr;

  logic                              we;
  logic [AW-1:0]                     waddr;
  logic [ple_pkg::DATA_W-1:0]        wdata;
  logic [AW-1:0]                     raddr;
  logic [ple_pkg::DATA_W-1:0]        rdata;

  logic [XW-1:0] pos_x, cnt_x, wr_x;
  logic [AW-1:0] pos_a, cnt_a;
  logic          up;
  logic          pos_bad;
  logic          full;

  assign pos_x = XW'(pos_q);
  assign cnt_x = XW'(count);
  assign wr_x  = XW'(wr_ptr);
  assign pos_a = AW'(pos_q);
  assign cnt_a = count[AW-1:0];
  assign up    = (cmd_q == ple_pkg::CMD_INSERT);
  assign full  = (cnt_x == XW'(CAPACITY));

  always_comb begin
    pos_bad = up ? (pos_x > cnt_x) : (pos_x >= cnt_x);
    st.cmd        = cmd_q;
    st.err        = pos_bad || (up && full);
    st.no_shift   = up ? (pos_x == cnt_x) : (pos_x + XW'(1) == cnt_x);
    st.shift_last = up ? (wr_x == pos_x + XW'(1)) : (wr_x + XW'(2) == cnt_x);
    st.scan_last  = (wr_x + XW'(1) == cnt_x);
    st.count_one  = (cnt_x == XW'(1));
  end

  // memory port steering
  always_comb begin
    we    = 1'b0;
    waddr = wr_ptr;
    wdata = rdata;
    raddr = rd_ptr;
    if (ctl.rd_pos) raddr = pos_a;
    if (ctl.sh_prime) raddr = up ? (cnt_a - AW'(1)) : (pos_a + AW'(1));
    if (ctl.sc_prime) raddr = '0;
    if (ctl.sh_run) we = 1'b1;
    if (ctl.wr_val) begin
      we    = 1'b1;
      waddr = pos_a;
      wdata = val_q;
    end
    if (ctl.wr_moved) begin
      we    = 1'b1;
      waddr = cnt_a - AW'(1);
      wdata = moved;
    end
  end

  ple_ram #(
    .WIDTH (ple_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= ple_pkg::cmd_t'(cmd);
      pos_q <= pos;
      val_q <= value;
    end
    if (ctl.set_result) begin
      data_r <= ple_pkg::NEG_ONE;
      if (pos_bad) begin
        status_r <= ple_pkg::ST_RANGE;
      end else if (up && full) begin
        status_r <= ple_pkg::ST_FULL;
      end else begin
        status_r <= ple_pkg::ST_OK;
      end
    end
    if (ctl.cap_query) data_r <= rdata;
    if (ctl.cap_moved) moved <= rdata;
    if (ctl.sh_prime) begin
      rd_ptr <= up ? (cnt_a - AW'(2)) : (pos_a + AW'(2));
      wr_ptr <= up ? cnt_a : pos_a;
    end
    if (ctl.sh_run) begin
      rd_ptr <= up ? (rd_ptr - AW'(1)) : (rd_ptr + AW'(1));
      wr_ptr <= up ? (wr_ptr - AW'(1)) : (wr_ptr + AW'(1));
    end
    if (ctl.sc_prime) begin
      rd_ptr <= AW'(1);
      wr_ptr <= '0;
    end
    if (ctl.sc_run) begin
      rd_ptr <= rd_ptr + AW'(1);
      wr_ptr <= wr_ptr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      max_r <= ple_pkg::NEG_ONE;
    end else begin
      if (ctl.wr_val) begin
        count <= count + CW'(1);
        if (count == '0 || val_q > max_r) max_r <= val_q;
      end
      if (ctl.rem_fin) count <= count - CW'(1);
      if (ctl.max_clear) max_r <= ple_pkg::NEG_ONE;
      if (ctl.sc_run) begin
        if (wr_ptr == '0 || $signed(rdata) > max_r) max_r <= rdata;
      end
    end
  end

  assign data    = data_r;
  assign length  = ple_pkg::LEN_W'(count);
  assign maximum = max_r;
  assign status  = status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_x <= XW'(CAPACITY))
    else $error("list length above capacity");

  a_empty_max: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (max_r == ple_pkg::NEG_ONE))
    else $error("empty list with stale maximum");

endmodule

/* hw/rtl/positional_list_engine.sv */
`timescale 1ns / 1ps

// ordered list of up to CAPACITY signed words in one simple dual-port ram
// (one write and one registered read per cycle). a word is taken when start
// is high and busy is low; its result appears for exactly one cycle with done
// high and cannot be held off. busy stays high until the cycle after done.
// after the accept, a rejected command goes from decode straight to done, a
// query adds a read capture, an insert shifts the entries at and after the
// position up and writes the value, a move captures the word, shifts the rest
// down and writes it at the end, and a remove shifts down, then rescans the
// maximum, reading every remaining entry once. the worst case is set by the
// one read port walking the list. no clearing pass runs after reset.
module positional_list_engine #(
  parameter int CAPACITY = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [1:0]                          cmd,
  input  logic [ple_pkg::POS_W-1:0]           pos,
  input  logic signed [ple_pkg::DATA_W-1:0]   value,
  output logic                                busy,
  output logic                                done,
  output logic signed [ple_pkg::DATA_W-1:0]   data,
  output logic [ple_pkg::LEN_W-1:0]           length,
  output logic signed [ple_pkg::DATA_W-1:0]   maximum,
  output logic [1:0]                          status
);

  ple_pkg::ctl_t  ctl;
  ple_pkg::stat_t st;

  ple_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  ple_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .cmd     (cmd),
    .pos     (pos),
    .value   (value),
    .st      (st),
    .data    (data),
    .length  (length),
    .maximum (maximum),
    .status  (status)
  );

  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy after result word");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted word did not start work");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (done && status == ple_pkg::ST_FULL) |-> (length == ple_pkg::LEN_W'(CAPACITY)))
    else $error("full status with list not full");

endmodule

/* bench/positional_list_engine_tb.sv */
`timescale 1ns / 1ps

module positional_list_engine_tb;
  import ple_pkg::*;

  localparam int CAP = 1024;
  localparam int STALL_LIMIT = 10000;
  localparam int DRAIN_CYCLES = 100;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t WORD_MIN = 32'sh8000_0000;
  localparam word_t WORD_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    word_t            data;
    logic [LEN_W-1:0] length;
    word_t            maximum;
    status_t          status;
  } outcome_t;

  typedef struct packed {
    cmd_t             op;
    logic [POS_W-1:0] at;
    word_t            val;
    logic             fixed;
    outcome_t         want;
  } step_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic [1:0]          cmd;
  logic [POS_W-1:0]    pos;
  word_t               value;
  logic                busy;
  logic                done;
  word_t               data;
  logic [LEN_W-1:0]    length;
  word_t               maximum;
  logic [1:0]          status;

  word_t    shadow [CAP];
  int       shadow_len;
  step_t    plan_q [$];
  outcome_t expect_q [$];
  step_t    script [$];
  int       idle_pct;
  int       errors;
  int       quiet;

  positional_list_engine #(
    .CAPACITY(CAP)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .pos(pos),
    .value(value),
    .busy(busy),
    .done(done),
    .data(data),
    .length(length),
    .maximum(maximum),
    .status(status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic outcome_t apply_word(cmd_t op, int unsigned at, word_t val);
    outcome_t r;
    word_t    moved;
    word_t    best;
    int       k;
    r.data = NEG_ONE;
    r.status = ST_OK;
    case (op)
      CMD_INSERT: begin
        if (at > shadow_len) begin
          r.status = ST_RANGE;
        end else if (shadow_len >= CAP) begin
          r.status = ST_FULL;
        end else begin
          for (k = shadow_len; k > at; k--) shadow[k] = shadow[k-1];
          shadow[at] = val;
          shadow_len++;
        end
      end
      CMD_REMOVE: begin
        if (at >= shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          for (k = at; k + 1 < shadow_len; k++) shadow[k] = shadow[k+1];
          shadow_len--;
        end
      end
      CMD_MOVE: begin
        if (at >= shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          moved = shadow[at];
          for (k = at; k + 1 < shadow_len; k++) shadow[k] = shadow[k+1];
          shadow[shadow_len-1] = moved;
        end
      end
      default: begin
        if (at >= shadow_len) r.status = ST_RANGE;
        else r.data = shadow[at];
      end
    endcase
    best = NEG_ONE;
    for (k = 0; k < shadow_len; k++) begin
      if (k == 0 || shadow[k] > best) best = shadow[k];
    end
    r.length = LEN_W'(shadow_len);
    r.maximum = best;
    return r;
  endfunction

  function automatic step_t row(cmd_t op, int unsigned at, word_t val, logic fixed,
                                word_t d, int unsigned n, word_t m, status_t s);
    step_t t;
    t.op = op;
    t.at = POS_W'(at);
    t.val = val;
    t.fixed = fixed;
    t.want.data = d;
    t.want.length = LEN_W'(n);
    t.want.maximum = m;
    t.want.status = s;
    return t;
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(cmd_t op);
    int unsigned span;
    int unsigned roll;
    span = (op == CMD_INSERT) ? shadow_len + 1 : shadow_len;
    roll = $urandom_range(99, 0);
    if (roll < 80 && span != 0) return POS_W'($urandom_range(span - 1, 0));
    if (roll < 92) return POS_W'(span + $urandom_range(1, 0));
    return POS_W'($urandom());
  endfunction

  function automatic word_t pick_val();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 3) return WORD_MIN;
    if (roll < 6) return WORD_MAX;
    if (roll < 9) return NEG_ONE;
    if (roll < 40) return word_t'(int'($urandom_range(20, 0)) - 10);
    return word_t'($urandom());
  endfunction

  task automatic issue(step_t s);
    int gap;
    gap = 0;
    if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) gap = $urandom_range(12, 1);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    plan_q.push_back(s);
    start <= 1'b1;
    cmd <= s.op;
    pos <= s.at;
    value <= s.val;
    do @(posedge clk); while (busy);
  endtask

  task automatic random_burst(int items, int keep_below);
    step_t       s;
    int unsigned roll;
    repeat (items) begin
      s = '0;
      roll = $urandom_range(99, 0);
      if (shadow_len == 0)
        s.op = (roll < 70) ? CMD_INSERT : cmd_t'($urandom_range(3, 1));
      else if (shadow_len < keep_below)
        s.op = (roll < 40) ? CMD_INSERT : (roll < 60) ? CMD_REMOVE :
               (roll < 75) ? CMD_MOVE : CMD_QUERY;
      else
        s.op = (roll < 20) ? CMD_INSERT : (roll < 55) ? CMD_REMOVE :
               (roll < 70) ? CMD_MOVE : CMD_QUERY;
      s.at = pick_pos(s.op);
      s.val = pick_val();
      issue(s);
    end
  endtask

  always @(posedge clk) begin : monitor
    step_t    plan;
    outcome_t got;
    outcome_t want;
    outcome_t seen;
    if (!rst) begin
      if (start && !busy) begin
        plan = plan_q.pop_front();
        got = apply_word(cmd_t'(cmd), pos, value);
        expect_q.push_back(plan.fixed ? plan.want : got);
      end
      if (done) begin
        seen.data = data;
        seen.length = length;
        seen.maximum = maximum;
        seen.status = status_t'(status);
        if (expect_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected word: data %0d length %0d max %0d status %0d",
                     seen.data, seen.length, seen.maximum, seen.status);
        end else begin
          want = expect_q.pop_front();
          if (seen !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected data %0d length %0d max %0d status %0d, %s",
                       want.data, want.length, want.maximum, want.status, "got");
            if (errors <= 10)
              $display("          actual   data %0d length %0d max %0d status %0d",
                       seen.data, seen.length, seen.maximum, seen.status);
          end
        end
      end
      if ((start && !busy) || done) begin
        quiet <= 0;
      end else if (quiet == STALL_LIMIT) begin
        $display("** positional_list_engine: FAILED **");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    step_t s;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    pos = '0;
    value = '0;
    idle_pct = 0;
    errors = 0;
    quiet = 0;
    shadow_len = 0;
    for (int k = 0; k < CAP; k++) shadow[k] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty list, edges of the value range, single-entry corner cases
    script.push_back(row(CMD_QUERY, 0, 0, 1, NEG_ONE, 0, NEG_ONE, ST_RANGE));
    script.push_back(row(CMD_REMOVE, 0, 0, 1, NEG_ONE, 0, NEG_ONE, ST_RANGE));
    script.push_back(row(CMD_MOVE, 0, 0, 1, NEG_ONE, 0, NEG_ONE, ST_RANGE));
    script.push_back(row(CMD_INSERT, 1, 5, 1, NEG_ONE, 0, NEG_ONE, ST_RANGE));
    script.push_back(row(CMD_INSERT, 2047, 5, 1, NEG_ONE, 0, NEG_ONE, ST_RANGE));
    script.push_back(row(CMD_INSERT, 0, WORD_MIN, 1, NEG_ONE, 1, WORD_MIN, ST_OK));
    script.push_back(row(CMD_INSERT, 1, WORD_MAX, 1, NEG_ONE, 2, WORD_MAX, ST_OK));
    script.push_back(row(CMD_INSERT, 0, NEG_ONE, 1, NEG_ONE, 3, WORD_MAX, ST_OK));
    script.push_back(row(CMD_QUERY, 1, 0, 1, WORD_MIN, 3, WORD_MAX, ST_OK));
    script.push_back(row(CMD_QUERY, 2, 0, 1, WORD_MAX, 3, WORD_MAX, ST_OK));
    script.push_back(row(CMD_QUERY, 3, 0, 1, NEG_ONE, 3, WORD_MAX, ST_RANGE));
    script.push_back(row(CMD_QUERY, 2047, 0, 1, NEG_ONE, 3, WORD_MAX, ST_RANGE));
    script.push_back(row(CMD_MOVE, 2, 0, 1, NEG_ONE, 3, WORD_MAX, ST_OK));
    script.push_back(row(CMD_MOVE, 0, 0, 0, NEG_ONE, 0, NEG_ONE, ST_OK));
    script.push_back(row(CMD_INSERT, 3, 0, 0, NEG_ONE, 0, NEG_ONE, ST_OK));
    script.push_back(row(CMD_REMOVE, 4, 0, 1, NEG_ONE, 4, WORD_MAX, ST_RANGE));
    script.push_back(row(CMD_REMOVE, 1, 0, 0, NEG_ONE, 0, NEG_ONE, ST_OK));
    script.push_back(row(CMD_QUERY, 0, 0, 0, NEG_ONE, 0, NEG_ONE, ST_OK));
    script.push_back(row(CMD_REMOVE, 2, 0, 0, NEG_ONE, 0, NEG_ONE, ST_OK));
    script.push_back(row(CMD_REMOVE, 0, 0, 0, NEG_ONE, 0, NEG_ONE, ST_OK));
    script.push_back(row(CMD_MOVE, 0, 0, 1, NEG_ONE, 1, NEG_ONE, ST_OK));
    script.push_back(row(CMD_REMOVE, 0, 0, 1, NEG_ONE, 0, NEG_ONE, ST_OK));
    script.push_back(row(CMD_INSERT, 0, WORD_MAX, 1, NEG_ONE, 1, WORD_MAX, ST_OK));
    script.push_back(row(CMD_REMOVE, 1, 0, 1, NEG_ONE, 1, WORD_MAX, ST_RANGE));
    foreach (script[i]) issue(script[i]);

    idle_pct = 0;
    random_burst(145, 24);
    idle_pct = 65;
    random_burst(145, 24);
    idle_pct = 8;
    random_burst(145, 24);
    idle_pct = 0;
    random_burst(145, 24);

    // grow the list to capacity, mostly by appending
    idle_pct = 8;
    while (shadow_len < CAP) begin
      s = '0;
      s.op = CMD_INSERT;
      s.at = ($urandom_range(99, 0) < 3) ? POS_W'($urandom_range(shadow_len, 0))
                                         : POS_W'(shadow_len);
      s.val = pick_val();
      issue(s);
    end

    // full list
    idle_pct = 65;
    script.delete();
    script.push_back(row(CMD_INSERT, CAP, 1, 0, NEG_ONE, 0, NEG_ONE, ST_OK));
    script.push_back(row(CMD_INSERT, 0, 1, 0, NEG_ONE, 0, NEG_ONE, ST_OK));
    script.push_back(row(CMD_INSERT, CAP + 1, 1, 0, NEG_ONE, 0, NEG_ONE, ST_OK));
    script.push_back(row(CMD_INSERT, 2047, 1, 0, NEG_ONE, 0, NEG_ONE, ST_OK));
    script.push_back(row(CMD_QUERY, 0, 0, 0, NEG_ONE, 0, NEG_ONE, ST_OK));
    script.push_back(row(CMD_QUERY, CAP - 1, 0, 0, NEG_ONE, 0, NEG_ONE, ST_OK));
    script.push_back(row(CMD_QUERY, CAP, 0, 0, NEG_ONE, 0, NEG_ONE, ST_OK));
    script.push_back(row(CMD_MOVE, 0, 0, 0, NEG_ONE, 0, NEG_ONE, ST_OK));
    script.push_back(row(CMD_MOVE, CAP - 1, 0, 0, NEG_ONE, 0, NEG_ONE, ST_OK));
    script.push_back(row(CMD_REMOVE, CAP - 1, 0, 0, NEG_ONE, 0, NEG_ONE, ST_OK));
    script.push_back(row(CMD_INSERT, 0, WORD_MAX, 0, NEG_ONE, 0, NEG_ONE, ST_OK));
    script.push_back(row(CMD_INSERT, CAP, 1, 0, NEG_ONE, 0, NEG_ONE, ST_OK));
    script.push_back(row(CMD_REMOVE, 0, 0, 0, NEG_ONE, 0, NEG_ONE, ST_OK));
    script.push_back(row(CMD_REMOVE, 512, 0, 0, NEG_ONE, 0, NEG_ONE, ST_OK));
    script.push_back(row(CMD_QUERY, 700, 0, 0, NEG_ONE, 0, NEG_ONE, ST_OK));
    foreach (script[i]) issue(script[i]);

    @(negedge clk);
    start <= 1'b0;
    while (expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** positional_list_engine: PASSED **");
    end else begin
      $display("** positional_list_engine: FAILED **");
    end
    $finish;
  end

endmodule
